FILE: hdl/madt_table_scanner_assert.svh
// ----------------------------------------------------------------------------
// madt_table_scanner_assert.svh
// Assertion macros used by the table scanner RTL.
// ----------------------------------------------------------------------------
`ifndef MADT_TABLE_SCANNER_ASSERT_SVH
`define MADT_TABLE_SCANNER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MADT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MADT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/madt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_pkg
// Constants, record codes and shared types of the table scanner.
// ----------------------------------------------------------------------------
package madt_pkg;

	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [31:0] HDR_MIN_LEN  = 32'd36;
	localparam logic [31:0] REC_BASE     = 32'd44;
	localparam logic [31:0] SIG_END      = 32'd4;
	localparam logic [31:0] LEN_END      = 32'd8;
	localparam logic [31:0] LAPIC_BEGIN  = 32'd36;
	localparam logic [31:0] LAPIC_END    = 32'd40;

	localparam logic [7:0] REC_HDR_LEN    = 8'd2;
	localparam logic [7:0] LAPIC_MIN_LEN  = 8'd8;
	localparam logic [7:0] IOAPIC_MIN_LEN = 8'd12;
	localparam logic [7:0] FLAG_ENABLED   = 8'h01;
	localparam logic [7:0] OUT_FLAGS_OFS  = 8'd4;

	typedef enum logic [7:0] {
		REC_LOCAL_APIC = 8'h00,
		REC_IO_APIC    = 8'h01
	} rec_type_t;

	// "APIC" in byte order
	localparam logic [7:0] SIG_BYTES [4] = '{8'h41, 8'h50, 8'h49, 8'h43};

	typedef struct packed {
		logic        fire;
		logic        clear;
		logic [31:0] pos;
		logic [31:0] len;
		logic [7:0]  data;
	} walk_ctl_t;

endpackage

FILE: hdl/madt_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_byte_if
// Byte stream channel: one table byte per transfer with a last marker.
// ----------------------------------------------------------------------------
interface madt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

FILE: hdl/madt_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_result_if
// Result channel: one summary per scanned table.
// ----------------------------------------------------------------------------
interface madt_result_if;
	logic        valid;
	logic        ready;
	logic        table_valid;
	logic        is_madt;
	logic [31:0] table_length;
	logic [31:0] apic_base;
	logic [15:0] cpu_total;
	logic [15:0] ioapic_total;

	modport source (output valid, output table_valid, output is_madt, output table_length,
		output apic_base, output cpu_total, output ioapic_total, input ready);
	modport sink   (input valid, input table_valid, input is_madt, input table_length,
		input apic_base, input cpu_total, input ioapic_total, output ready);
endinterface

FILE: hdl/madt_rec_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_rec_walker
// Follows the type/length records after the fixed header and counts enabled
// processor records and I/O APIC records, saturating.
// ----------------------------------------------------------------------------
module madt_rec_walker #(
	parameter int COUNT_WIDTH = madt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  madt_pkg::walk_ctl_t    ctl,
	output logic [COUNT_WIDTH-1:0] cpu_next,
	output logic [COUNT_WIDTH-1:0] io_next
);

	logic [31:0]            rec_start_q;
	logic [7:0]             rec_type_q;
	logic [7:0]             rec_len_q;
	logic                   stopped_q;
	logic [COUNT_WIDTH-1:0] cpu_cnt_q;
	logic [COUNT_WIDTH-1:0] io_cnt_q;

	logic [31:0] rec_start_nx;
	logic [7:0]  rec_type_nx;
	logic [7:0]  rec_len_nx;
	logic        stopped_nx;

	logic        active;
	logic [32:0] pos_w;
	logic [32:0] len_w;
	logic [32:0] rs_w;
	logic [32:0] rec_end_w;

	assign pos_w = {1'b0, ctl.pos};
	assign len_w = {1'b0, ctl.len};
	assign rs_w  = {1'b0, rec_start_q};

	assign active = !stopped_q && (ctl.pos >= madt_pkg::REC_BASE) && (ctl.pos < ctl.len);

	always_comb begin
		rec_start_nx = rec_start_q;
		rec_type_nx  = rec_type_q;
		rec_len_nx   = rec_len_q;
		stopped_nx   = stopped_q;
		cpu_next     = cpu_cnt_q;
		io_next      = io_cnt_q;
		rec_end_w    = '0;
		if (active) begin
			if (pos_w == rs_w) begin
				if (rs_w + 33'(madt_pkg::REC_HDR_LEN) > len_w) begin
					stopped_nx = 1'b1;
				end else begin
					rec_type_nx = ctl.data;
				end
			end else if (pos_w == rs_w + 33'd1) begin
				rec_len_nx = ctl.data;
				if (ctl.data < madt_pkg::REC_HDR_LEN || rs_w + 33'(ctl.data) > len_w) begin
					stopped_nx = 1'b1;
				end else if (rec_type_q == madt_pkg::REC_IO_APIC &&
						ctl.data >= madt_pkg::IOAPIC_MIN_LEN) begin
					if (!(&io_cnt_q)) io_next = io_cnt_q + 1'b1;
				end
			end else if (rec_type_q == madt_pkg::REC_LOCAL_APIC &&
					rec_len_q >= madt_pkg::LAPIC_MIN_LEN &&
					pos_w == rs_w + 33'(madt_pkg::OUT_FLAGS_OFS) &&
					(ctl.data & madt_pkg::FLAG_ENABLED) != 8'd0) begin
				if (!(&cpu_cnt_q)) cpu_next = cpu_cnt_q + 1'b1;
			end
			// advance to the next record on its final byte
			rec_end_w = rs_w + 33'(rec_len_nx) - 33'd1;
			if (!stopped_nx && pos_w != rs_w && pos_w == rec_end_w) begin
				rec_start_nx = rec_start_q + 32'(rec_len_nx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_start_q <= madt_pkg::REC_BASE;
			rec_type_q  <= '0;
			rec_len_q   <= '0;
			stopped_q   <= 1'b0;
			cpu_cnt_q   <= '0;
			io_cnt_q    <= '0;
		end else if (ctl.fire) begin
			if (ctl.clear) begin
				rec_start_q <= madt_pkg::REC_BASE;
				rec_type_q  <= '0;
				rec_len_q   <= '0;
				stopped_q   <= 1'b0;
				cpu_cnt_q   <= '0;
				io_cnt_q    <= '0;
			end else begin
				rec_start_q <= rec_start_nx;
				rec_type_q  <= rec_type_nx;
				rec_len_q   <= rec_len_nx;
				stopped_q   <= stopped_nx;
				cpu_cnt_q   <= cpu_next;
				io_cnt_q    <= io_next;
			end
		end
	end

endmodule

FILE: hdl/madt_table_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_table_scanner
// Scans one system description table byte stream and reports its summary.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : one table byte per transfer in memory order, last set on the
//            final byte. Each byte updates the header checks, the checksum
//            and the record walk in the cycle it is taken.
//   result : one summary per table, loaded into an output register at the
//            transfer of the last byte and shown on the next cycle.
// Throughput: one byte per cycle, sustained; the only limit is the single
//   output register, which holds a summary until it is taken.
// Stall: while a summary waits on result.ready, bytes.ready drops, so the
//   next table is held off until the summary register frees up; if the
//   sink takes it in the same cycle, streaming goes on without a gap.
// Reset: arst_n clears all scan state and the output valid at once; no
//   clearing pass is needed. State also returns to its reset values after
//   every last byte, ready for the next table.
// ----------------------------------------------------------------------------
`include "madt_table_scanner_assert.svh"

module madt_table_scanner #(
	parameter int COUNT_WIDTH = madt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	madt_byte_if.sink            bytes,
	madt_result_if.source        result
);

	logic [31:0] pos_q;
	logic [7:0]  sum_q;
	logic [31:0] len_q;
	logic        sig_q;
	logic [31:0] lapic_q;
	logic        out_valid_q;

	logic [31:0] len_nx;
	logic [7:0]  sum_nx;
	logic        sig_nx;
	logic [31:0] lapic_nx;
	logic        tbl_ok;
	logic        madt_ok;
	logic        fire;

	logic [COUNT_WIDTH-1:0] cpu_next;
	logic [COUNT_WIDTH-1:0] io_next;
	logic [31:0]            cpu_wide;
	logic [31:0]            io_wide;
	madt_pkg::walk_ctl_t    walk_ctl;

	assign bytes.ready = !out_valid_q || result.ready;
	assign fire        = bytes.valid && bytes.ready;

	always_comb begin
		len_nx   = len_q;
		sig_nx   = sig_q;
		lapic_nx = lapic_q;
		if (pos_q < madt_pkg::SIG_END) begin
			if (bytes.data_byte != madt_pkg::SIG_BYTES[pos_q[1:0]]) sig_nx = 1'b0;
		end else if (pos_q < madt_pkg::LEN_END) begin
			len_nx[{pos_q[1:0], 3'b000} +: 8] = bytes.data_byte;
		end
		if (pos_q >= madt_pkg::LAPIC_BEGIN && pos_q < madt_pkg::LAPIC_END) begin
			lapic_nx[{pos_q[1:0], 3'b000} +: 8] = bytes.data_byte;
		end
		// signature and length bytes always enter the sum, the rest only inside the length
		if (pos_q < madt_pkg::LEN_END || pos_q < len_nx) begin
			sum_nx = sum_q + bytes.data_byte;
		end else begin
			sum_nx = sum_q;
		end
	end

	assign tbl_ok = (len_nx >= madt_pkg::HDR_MIN_LEN) &&
		({1'b0, pos_q} + 33'd1 >= {1'b0, len_nx}) && (sum_nx == 8'd0);
	assign madt_ok = sig_nx && (pos_q >= madt_pkg::SIG_END - 32'd1);

	assign walk_ctl.fire  = fire;
	assign walk_ctl.clear = bytes.last;
	assign walk_ctl.pos   = pos_q;
	assign walk_ctl.len   = len_nx;
	assign walk_ctl.data  = bytes.data_byte;

	madt_rec_walker #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (walk_ctl),
		.cpu_next (cpu_next),
		.io_next  (io_next)
	);

	assign cpu_wide = 32'(cpu_next);
	assign io_wide  = 32'(io_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			len_q   <= '0;
			sig_q   <= 1'b1;
			lapic_q <= '0;
		end else if (fire) begin
			if (bytes.last) begin
				pos_q   <= '0;
				sum_q   <= '0;
				len_q   <= '0;
				sig_q   <= 1'b1;
				lapic_q <= '0;
			end else begin
				// hold at the top on very long streams
				if (pos_q != '1) pos_q <= pos_q + 32'd1;
				sum_q   <= sum_nx;
				len_q   <= len_nx;
				sig_q   <= sig_nx;
				lapic_q <= lapic_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && bytes.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && bytes.last) begin
			result.table_valid  <= tbl_ok;
			result.is_madt      <= madt_ok;
			result.table_length <= len_nx;
			result.apic_base    <= lapic_nx;
			if (tbl_ok && madt_ok) begin
				result.cpu_total    <= (cpu_wide > 32'hFFFF) ? 16'hFFFF : cpu_wide[15:0];
				result.ioapic_total <= (io_wide > 32'hFFFF) ? 16'hFFFF : io_wide[15:0];
			end else begin
				result.cpu_total    <= 16'd0;
				result.ioapic_total <= 16'd0;
			end
		end
	end

	assign result.valid = out_valid_q;

	`MADT_ASSERT_NOW(a_stall_blocks_input, result.valid && !result.ready, !bytes.ready,
		"byte taken while summary register is full")
	`MADT_ASSERT_NEXT(a_last_gives_result, fire && bytes.last, result.valid,
		"no summary after last byte transfer")
	`MADT_ASSERT_NEXT(a_pos_clears_after_last, fire && bytes.last, pos_q == 32'd0,
		"byte position not cleared after last byte")
	`MADT_ASSERT_NOW(a_counts_gated,
		result.valid && (result.cpu_total != 16'd0 || result.ioapic_total != 16'd0),
		result.table_valid && result.is_madt, "counts reported for an invalid table")
	`MADT_ASSERT_NEXT(a_pos_advances, fire && !bytes.last,
		pos_q == $past(pos_q) + 32'd1 || $past(pos_q) == 32'hFFFF_FFFF,
		"byte position did not advance")

endmodule

FILE: sim/tb_madt_table_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_madt_table_scanner
// Streams whole tables into the scanner and checks every summary it reports.
// A scoreboard class tracks the scan state of the table in flight, byte by
// byte, and queues the summary expected at each last byte. Directed tables
// cover the header limits, the checksum, the signature, short and over-long
// streams and malformed records. Random tables follow, mostly well formed
// with random content and the rest damaged or noise. Both sides idle at
// random, and the result side holds off once for a long stretch so that the
// scanner stalls its input.
// ----------------------------------------------------------------------------
module tb_madt_table_scanner;
	import madt_pkg::*;

	localparam int CYCLE_LIMIT = 40_000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 1450;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic        table_valid;
		logic        is_madt;
		logic [31:0] table_length;
		logic [31:0] apic_base;
		logic [15:0] cpu_total;
		logic [15:0] ioapic_total;
	} summary_t;

	class madt_summary_board;
		logic [31:0] pos;
		logic [7:0]  csum;
		logic [31:0] decl_len;
		logic        sig_ok;
		logic [31:0] lapic;
		logic [31:0] rec_start;
		logic [7:0]  rec_type;
		logic [7:0]  rec_len;
		logic        stopped;
		logic [15:0] cpus;
		logic [15:0] ioapics;
		summary_t    pending[$];
		int          errors;

		function new();
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			pos = 32'd0;
			csum = 8'd0;
			decl_len = 32'd0;
			sig_ok = 1'b1;
			lapic = 32'd0;
			rec_start = REC_BASE;
			rec_type = 8'd0;
			rec_len = 8'd0;
			stopped = 1'b0;
			cpus = 16'd0;
			ioapics = 16'd0;
		endfunction

		function logic [15:0] bump(logic [15:0] c);
			return (c == 16'hFFFF) ? c : c + 16'd1;
		endfunction

		// advance the scan by one accepted byte; queue a summary on last
		function void take_byte(logic [7:0] b, logic l);
			logic [31:0] p;
			logic [63:0] len, rs, seen;
			logic        ok_tbl, ok_sig;
			summary_t    s;
			p = pos;
			rs = 64'(rec_start);
			if (p < SIG_END) begin
				if (b != SIG_BYTES[p[1:0]])
					sig_ok = 1'b0;
			end else if (p < LEN_END) begin
				decl_len = decl_len | (32'(b) << (8 * (p - SIG_END)));
			end
			len = 64'(decl_len);
			if (p < LEN_END || 64'(p) < len)
				csum = csum + b;
			if (p >= LAPIC_BEGIN && p < LAPIC_END)
				lapic = lapic | (32'(b) << (8 * (p - LAPIC_BEGIN)));
			if (!stopped && p >= REC_BASE && 64'(p) < len) begin
				if (64'(p) == rs) begin
					if (rs + 64'(REC_HDR_LEN) > len)
						stopped = 1'b1;
					else
						rec_type = b;
				end else if (64'(p) == rs + 64'd1) begin
					rec_len = b;
					if (b < REC_HDR_LEN || rs + 64'(b) > len)
						stopped = 1'b1;
					else if (rec_type == REC_IO_APIC && b >= IOAPIC_MIN_LEN)
						ioapics = bump(ioapics);
				end else if (rec_type == REC_LOCAL_APIC && rec_len >= LAPIC_MIN_LEN &&
						64'(p) == rs + 64'(OUT_FLAGS_OFS) && (b & FLAG_ENABLED) != 8'd0) begin
					cpus = bump(cpus);
				end
				// step to the next record on its final byte
				if (!stopped && 64'(p) != rs && 64'(p) == rs + 64'(rec_len) - 64'd1)
					rec_start = 32'(rs + 64'(rec_len));
			end
			if (pos != 32'hFFFF_FFFF)
				pos = pos + 32'd1;
			if (l) begin
				seen = 64'(p) + 64'd1;
				ok_tbl = (len >= 64'(HDR_MIN_LEN)) && (seen >= len) && (csum == 8'd0);
				ok_sig = sig_ok && (seen >= 64'(SIG_END));
				s.table_valid = ok_tbl;
				s.is_madt = ok_sig;
				s.table_length = decl_len;
				s.apic_base = lapic;
				s.cpu_total = (ok_tbl && ok_sig) ? cpus : 16'd0;
				s.ioapic_total = (ok_tbl && ok_sig) ? ioapics : 16'd0;
				pending.push_back(s);
				clear_scan();
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("tb: mismatch at %0t: %s", $time, what);
		endtask

		task check_summary(summary_t got);
			summary_t want;
			if (pending.size() == 0) begin
				report("summary arrived with none pending");
				return;
			end
			want = pending.pop_front();
			if (got.table_valid !== want.table_valid)
				report($sformatf("table_valid got %b want %b", got.table_valid,
					want.table_valid));
			if (got.is_madt !== want.is_madt)
				report($sformatf("is_madt got %b want %b", got.is_madt, want.is_madt));
			if (got.table_length !== want.table_length)
				report($sformatf("table_length got %h want %h", got.table_length,
					want.table_length));
			if (got.apic_base !== want.apic_base)
				report($sformatf("apic_base got %h want %h", got.apic_base,
					want.apic_base));
			if (got.cpu_total !== want.cpu_total)
				report($sformatf("cpu_total got %0d want %0d", got.cpu_total,
					want.cpu_total));
			if (got.ioapic_total !== want.ioapic_total)
				report($sformatf("ioapic_total got %0d want %0d", got.ioapic_total,
					want.ioapic_total));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle = 1'b0;
	bit   hold_off_req = 1'b0;
	int   cycle_count = 0;
	int   sent_items = 0;

	madt_summary_board sb = new();

	madt_byte_if   bytes_if();
	madt_result_if result_if();

	madt_table_scanner DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if),
		.result (result_if)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- builders

	// 44 random header bytes; signature good or broken in one byte
	function automatic void put_header(ref byte_q_t q, input bit sig_good);
		int k;
		q.delete();
		for (int i = 0; i < 44; i++)
			q.push_back(8'($urandom));
		for (int i = 0; i < 4; i++)
			q[i] = SIG_BYTES[i];
		if (!sig_good) begin
			k = $urandom_range(3);
			q[k] = q[k] ^ 8'($urandom_range(1, 255));
		end
	endfunction

	// record with a given length field and a given number of bytes emitted
	function automatic void add_rec(ref byte_q_t q, input logic [7:0] rtype,
			input logic [7:0] rlen, input int nbytes, input bit enabled);
		int base;
		base = q.size();
		q.push_back(rtype);
		q.push_back(rlen);
		for (int i = 2; i < nbytes; i++)
			q.push_back(8'($urandom));
		if (rtype == REC_LOCAL_APIC && nbytes > 4)
			q[base + 4] = enabled ? (q[base + 4] | FLAG_ENABLED) : (q[base + 4] & ~FLAG_ENABLED);
	endfunction

	function automatic void add_random_rec(ref byte_q_t q);
		int r, n;
		r = $urandom_range(99);
		n = 0;
		if (r < 40) begin
			n = ($urandom_range(4) == 0) ? $urandom_range(9, 20) : 8;
			add_rec(q, REC_LOCAL_APIC, 8'(n), n, $urandom_range(3) != 0);
		end else if (r < 65) begin
			add_rec(q, REC_IO_APIC, 8'd12, 12, 1'b0);
		end else if (r < 75) begin
			n = $urandom_range(2, 7);
			add_rec(q, REC_LOCAL_APIC, 8'(n), n, 1'b1);
		end else if (r < 82) begin
			n = $urandom_range(2, 11);
			add_rec(q, REC_IO_APIC, 8'(n), n, 1'b0);
		end else begin
			n = $urandom_range(2, 20);
			add_rec(q, 8'($urandom), 8'(n), n, $urandom_range(1) != 0);
		end
	endfunction

	// write the length field and fix byte 9 so the covered bytes sum to zero
	function automatic void seal(ref byte_q_t q, input logic [31:0] len);
		logic [7:0] s;
		if (q.size() > 7)
			for (int i = 0; i < 4; i++)
				q[4 + i] = len[8 * i +: 8];
		if (q.size() > 9)
			q[9] = 8'd0;
		s = 8'd0;
		for (int i = 0; i < q.size(); i++)
			if (i < 8 || i < len)
				s = s + q[i];
		if (q.size() > 9 && len > 32'd9)
			q[9] = ~s + 8'd1;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic send_byte(input logic [7:0] d, input logic l);
		while (!no_idle && $urandom_range(99) < 22) begin
			bytes_if.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= d;
		bytes_if.last <= l;
		@(negedge clk);
		while (!bytes_if.ready)
			@(negedge clk);
		@(posedge clk);
		sb.take_byte(d, l);
		sent_items++;
	endtask

	task automatic send_table(ref byte_q_t q);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
	endtask

	task automatic run_directed();
		byte_q_t q;
		// header only, exact fit
		put_header(q, 1'b1);
		seal(q, q.size());
		send_table(q);
		// minimum length, address field beyond the stream
		put_header(q, 1'b1);
		q = q[0:35];
		seal(q, q.size());
		send_table(q);
		// one byte below the minimum length
		put_header(q, 1'b1);
		q = q[0:34];
		seal(q, q.size());
		send_table(q);
		// mix of counted and uncounted records
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b0);
		add_rec(q, REC_LOCAL_APIC, 8'd16, 16, 1'b1);
		add_rec(q, REC_IO_APIC, 8'd12, 12, 1'b0);
		add_rec(q, REC_IO_APIC, 8'd11, 11, 1'b0);
		add_rec(q, REC_LOCAL_APIC, 8'd7, 7, 1'b1);
		add_rec(q, 8'hFF, 8'd2, 2, 1'b0);
		add_rec(q, REC_IO_APIC, 8'd255, 255, 1'b0);
		seal(q, q.size());
		send_table(q);
		// all-ones body
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		for (int i = 10; i < q.size(); i++)
			if (i != 44 && i != 45)
				q[i] = 8'hFF;
		seal(q, q.size());
		send_table(q);
		// all-zero body
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b0);
		for (int i = 10; i < q.size(); i++)
			if (i != 45)
				q[i] = 8'h00;
		seal(q, q.size());
		send_table(q);
		// wrong signature, otherwise sound
		put_header(q, 1'b0);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		seal(q, q.size());
		send_table(q);
		// checksum off by one
		put_header(q, 1'b1);
		add_rec(q, REC_IO_APIC, 8'd12, 12, 1'b0);
		seal(q, q.size());
		q[9] = q[9] + 8'd1;
		send_table(q);
		// streams too short for the signature and for the length field
		q = '{8'h41};
		send_table(q);
		q = '{8'h41, 8'h50, 8'h49};
		send_table(q);
		q = '{8'h41, 8'h50, 8'h49, 8'h43};
		send_table(q);
		q = '{8'h41, 8'h50, 8'h49, 8'h43, 8'h30, 8'h00};
		send_table(q);
		// stream ends before the declared length
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		add_rec(q, REC_IO_APIC, 8'd12, 12, 1'b0);
		seal(q, q.size());
		q = q[0:q.size() - 5];
		send_table(q);
		// bytes past the declared length, shaped like a record
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		seal(q, q.size());
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		send_table(q);
		// one byte left at a record start
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		q.push_back(REC_IO_APIC);
		seal(q, q.size());
		send_table(q);
		// record length zero, then one, each followed by records not counted
		put_header(q, 1'b1);
		add_rec(q, REC_IO_APIC, 8'd0, 2, 1'b0);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		seal(q, q.size());
		send_table(q);
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd1, 2, 1'b0);
		add_rec(q, REC_IO_APIC, 8'd12, 12, 1'b0);
		seal(q, q.size());
		send_table(q);
		// record that runs past the declared length
		put_header(q, 1'b1);
		add_rec(q, REC_IO_APIC, 8'd12, 12, 1'b0);
		add_rec(q, REC_IO_APIC, 8'd12, 10, 1'b0);
		seal(q, q.size());
		send_table(q);
		// largest declared length with a short stream
		put_header(q, 1'b1);
		add_rec(q, REC_LOCAL_APIC, 8'd8, 8, 1'b1);
		seal(q, 32'hFFFF_FFFF);
		send_table(q);
	endtask

	function automatic void build_random_table(ref byte_q_t q);
		int m, n, k;
		m = $urandom_range(99);
		if (m < 6) begin
			// noise stream, sometimes with a good signature
			n = $urandom_range(1, 48);
			q.delete();
			for (int i = 0; i < n; i++)
				q.push_back(8'($urandom));
			if (n >= 4 && $urandom_range(1))
				for (int i = 0; i < 4; i++)
					q[i] = SIG_BYTES[i];
			return;
		end
		put_header(q, $urandom_range(9) != 0);
		n = $urandom_range(0, 5);
		for (int i = 0; i < n; i++)
			add_random_rec(q);
		if (m < 72) begin
			seal(q, q.size());
		end else if (m < 78) begin
			seal(q, q.size());
			k = $urandom_range(0, q.size() - 1);
			q[k] = q[k] ^ 8'($urandom_range(1, 255));
		end else if (m < 84) begin
			seal(q, q.size());
			k = $urandom_range(0, q.size() - 2);
			q = q[0:k];
		end else if (m < 89) begin
			seal(q, q.size());
			k = $urandom_range(1, 12);
			for (int i = 0; i < k; i++)
				q.push_back(8'($urandom));
		end else if (m < 93) begin
			if ($urandom_range(1))
				add_rec(q, 8'($urandom), 8'($urandom_range(1)), 2, 1'b1);
			else
				add_rec(q, 8'($urandom_range(1)), 8'($urandom_range(20, 255)), 8, 1'b1);
			add_random_rec(q);
			seal(q, q.size());
		end else if (m < 96) begin
			q.push_back(8'($urandom));
			seal(q, q.size());
		end else begin
			seal(q, $urandom_range(0, 35));
		end
	endfunction

	task automatic run_random();
		int      tables;
		byte_q_t q;
		tables = 0;
		while (sent_items < ITEM_TARGET || tables < 5) begin
			if (tables == 1)
				hold_off_req = 1'b1;
			no_idle = (tables >= 2 && tables < 5);
			build_random_table(q);
			send_table(q);
			tables++;
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------- result side

	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				// hold off while bytes keep coming, so the scanner backs up
				hold_off_req = 1'b0;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end
			result_if.ready <= no_idle || ($urandom_range(99) >= 22);
		end
	end

	always @(negedge clk) begin
		summary_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.table_valid = result_if.table_valid;
			got.is_madt = result_if.is_madt;
			got.table_length = result_if.table_length;
			got.apic_base = result_if.apic_base;
			got.cpu_total = result_if.cpu_total;
			got.ioapic_total = result_if.ioapic_total;
			sb.check_summary(got);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------- main

	initial begin
		arst_n <= 1'b0;
		bytes_if.valid <= 1'b0;
		bytes_if.data_byte <= 8'd0;
		bytes_if.last <= 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		bytes_if.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
